// ===== design/srht_pkg.sv =====
`timescale 1ns / 1ps

package srht_pkg;

    typedef enum logic [1:0] {
        OP_PROBE = 2'd0,
        OP_STORE = 2'd1,
        OP_AGE   = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK
    } t_state;

    // input word
    typedef struct packed {
        t_op                op;
        logic [63:0]        key;
        logic [6:0]         search_depth;
        logic signed [15:0] score_in;
        logic [1:0]         bound_kind;
        logic [15:0]        move_in;
    } t_req;

    // result word
    typedef struct packed {
        logic               hit;
        logic signed [7:0]  depth_out;
        logic signed [15:0] score_out;
        logic [1:0]         bound_out;
        logic [15:0]        move_out;
        logic               written;
        logic [7:0]         age_now;
    } t_rsp;

    // one table slot as held in memory
    typedef struct packed {
        logic [63:0]        key;
        logic signed [7:0]  depth;
        logic signed [15:0] score;
        logic [1:0]         bound;
        logic [15:0]        move;
        logic [7:0]         age;
    } t_entry;

    typedef struct packed {
        logic   en;
        t_entry ent;
    } t_wr;

    localparam logic signed [7:0] EMPTY_DEPTH = 8'shFF;

    localparam t_entry EMPTY_ENTRY = '{
        key:   64'd0,
        depth: EMPTY_DEPTH,
        score: 16'sd0,
        bound: 2'd0,
        move:  16'd0,
        age:   8'd0
    };

endpackage

// ===== design/search_result_hash_table_core.sv =====
`timescale 1ns / 1ps

// direct-mapped table of search results held in one synchronous memory of
// 2**floor(log2(TABLE_ENTRIES)) slots, indexed by the low key bits. the accept
// edge reads the slot; the look state then compares, and the edge that produces
// the result writes the slot back for a store and loads the result register.
// the read-then-write-back on the single memory means no new word is accepted
// until the last one has produced its result, even while results are taken.
// one further word is still taken while a result waits, and the input then
// stalls until that result leaves. after reset and after every clear word the
// block sweeps every slot of the memory, one slot a cycle, and takes no word
// until the sweep is done; the clear word's own result is offered at once.
module search_result_hash_table_core #(
    parameter int TABLE_ENTRIES = 4096
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  srht_pkg::t_req i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output srht_pkg::t_rsp o_out_data
);

    // largest power of two not above TABLE_ENTRIES
    localparam int SLOT_BITS = $clog2(TABLE_ENTRIES + 1) - 1;
    localparam int SLOTS     = 1 << SLOT_BITS;
    localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(SLOTS - 1);

    // slot memory
    srht_pkg::t_entry r_mem [SLOTS];

    srht_pkg::t_state r_state, n_state;
    logic [SLOT_BITS-1:0] r_clr_idx;
    logic [7:0]           r_gen;
    srht_pkg::t_req       r_req;
    srht_pkg::t_entry     r_rd;
    logic                 r_out_valid;
    srht_pkg::t_rsp       r_out;

    logic in_accept;
    logic produce;
    logic clearing;

    srht_pkg::t_rsp   look_rsp;
    srht_pkg::t_wr    look_wr;

    logic                 mem_we;
    logic [SLOT_BITS-1:0] mem_waddr;
    srht_pkg::t_entry     mem_wdata;

    // compare and replacement decision
    srht_lookup u_lookup (
        .i_req (r_req),
        .i_ent (r_rd),
        .i_gen (r_gen),
        .o_rsp (look_rsp),
        .o_wr  (look_wr)
    );

    // handshake and control outputs of the state machine
    always_comb begin
        o_in_ready = (r_state == srht_pkg::ST_IDLE);
        produce    = (r_state == srht_pkg::ST_LOOK) && (!r_out_valid || i_out_ready);
        clearing   = (r_state == srht_pkg::ST_CLEAR);
    end

    assign in_accept = i_in_valid && o_in_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            srht_pkg::ST_CLEAR: begin
                if (r_clr_idx == LAST_SLOT) begin
                    n_state = srht_pkg::ST_IDLE;
                end
            end
            srht_pkg::ST_IDLE: begin
                if (in_accept) begin
                    n_state = srht_pkg::ST_LOOK;
                end
            end
            srht_pkg::ST_LOOK: begin
                if (produce) begin
                    if (r_req.op == srht_pkg::OP_CLEAR) begin
                        n_state = srht_pkg::ST_CLEAR;
                    end else begin
                        n_state = srht_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = srht_pkg::ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= srht_pkg::ST_CLEAR;
            r_clr_idx   <= '0;
            r_gen       <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // the sweep counter wraps back to zero on its last slot
            if (clearing) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (produce) begin
                r_gen       <= look_rsp.age_now;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_req <= i_in_data;
        end
        if (produce) begin
            r_out <= look_rsp;
        end
    end

    // write port: sweep during a clear, write-back for an accepted store
    always_comb begin
        if (clearing) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_idx;
            mem_wdata = srht_pkg::EMPTY_ENTRY;
        end else begin
            mem_we    = produce && look_wr.en;
            mem_waddr = r_req.key[SLOT_BITS-1:0];
            mem_wdata = look_wr.ent;
        end
    end

    // reads happen only in idle, writes only in look or clear, so the two
    // never meet on one edge and no forwarding is needed
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_rd <= r_mem[i_in_data.key[SLOT_BITS-1:0]];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== design/srht_lookup.sv =====
`timescale 1ns / 1ps

// decides the result and the write-back for one word against the slot read
module srht_lookup (
    input  srht_pkg::t_req   i_req,
    input  srht_pkg::t_entry i_ent,
    input  logic [7:0]       i_gen,
    output srht_pkg::t_rsp   o_rsp,
    output srht_pkg::t_wr    o_wr
);

    logic occupied;
    logic same_key;
    logic fresh;
    logic deeper;
    logic refuse;

    assign occupied = !i_ent.depth[7];
    assign same_key = (i_ent.key == i_req.key);
    assign fresh    = (i_ent.age == i_gen);
    // an occupied slot has a non-negative depth, so the low bits compare directly
    assign deeper   = (i_ent.depth[6:0] > i_req.search_depth);
    assign refuse   = occupied && !same_key && fresh && deeper;

    always_comb begin
        o_rsp           = '0;
        o_rsp.depth_out = srht_pkg::EMPTY_DEPTH;
        o_rsp.age_now   = i_gen;
        o_wr.en         = 1'b0;
        o_wr.ent.key    = i_req.key;
        o_wr.ent.depth  = {1'b0, i_req.search_depth};
        o_wr.ent.score  = i_req.score_in;
        o_wr.ent.bound  = i_req.bound_kind;
        o_wr.ent.move   = i_req.move_in;
        o_wr.ent.age    = i_gen;
        unique case (i_req.op)
            srht_pkg::OP_PROBE: begin
                if (occupied && same_key) begin
                    o_rsp.hit       = 1'b1;
                    o_rsp.depth_out = i_ent.depth;
                    o_rsp.score_out = i_ent.score;
                    o_rsp.bound_out = i_ent.bound;
                    o_rsp.move_out  = i_ent.move;
                end
            end
            srht_pkg::OP_STORE: begin
                o_rsp.written = !refuse;
                o_wr.en       = !refuse;
            end
            srht_pkg::OP_AGE: begin
                o_rsp.age_now = i_gen + 8'd1;
            end
            srht_pkg::OP_CLEAR: begin
                o_rsp.age_now = 8'd0;
            end
            default: begin
                o_rsp.age_now = i_gen;
            end
        endcase
    end

endmodule

// ===== design/srht_check.sv =====
`timescale 1ns / 1ps

module srht_check (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input srht_pkg::t_req i_in_data,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input srht_pkg::t_rsp o_out_data
);

    // reset leaves the block sweeping with nothing to offer
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_ready)
        else $error("srht: output or input open straight after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("srht: stalled result changed or dropped");

    // no word is accepted while the previous one is still in flight
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("srht: word accepted while previous one in flight");

    // a hit comes only from an occupied slot and never from a store
    a_hit_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.hit |-> !o_out_data.written && !o_out_data.depth_out[7])
        else $error("srht: hit with negative depth or with write");

endmodule

bind search_result_hash_table_core srht_check u_srht_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
